// File: rtl/plom_pkg.sv
package plom_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned STOP_DEPTH  = 8;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SI_W  = (STOP_DEPTH > 1) ? $clog2(STOP_DEPTH) : 1;
  localparam int unsigned SC_W  = $clog2(STOP_DEPTH + 1);

  localparam logic [1:0] FLAG_FOK = 2'd1;
  localparam logic [1:0] FLAG_AON = 2'd2;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_FIND   = 3'd1;
  localparam logic [2:0] OP_MODIFY = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_CROSS  = 3'd4;
  localparam logic [2:0] OP_VOLUME = 3'd5;

  typedef enum logic [3:0] {
    EV_OPEN     = 4'd0,
    EV_CHANGE   = 4'd1,
    EV_CANCEL   = 4'd2,
    EV_FILL     = 4'd3,
    EV_TRADE    = 4'd4,
    EV_STOP     = 4'd5,
    EV_FOUND    = 4'd6,
    EV_NOTFOUND = 4'd7,
    EV_REMAIN   = 4'd8,
    EV_DONE     = 4'd9,
    EV_MISSING  = 4'd10,
    EV_CORRUPT  = 4'd11,
    EV_IGNORED  = 4'd12,
    EV_VOLUME   = 4'd13
  } ev_e;

  typedef enum logic [1:0] {ID_ITEM, ID_MAKER, ID_STOP, ID_ZERO} id_sel_e;
  typedef enum logic [2:0] {AMT_ZERO, AMT_NEED, AMT_REM, AMT_TF, AMT_SUM} amt_sel_e;
  typedef enum logic {TFN_ZERO, TFN_TF} tfn_sel_e;
  typedef enum logic [1:0] {RD_NONE, RD_IDX, RD_NEXT, RD_FRONT} rd_sel_e;
  typedef enum logic [2:0] {WR_NONE, WR_ITEM, WR_APPEND, WR_SHIFT, WR_PARTIAL} wr_sel_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] order_id;
    logic [31:0] order_price;
    logic [31:0] order_volume;
    logic [31:0] order_filled;
    logic [1:0]  order_flag;
    logic        is_stop;
    logic [31:0] stop_target_id;
  } item_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [31:0] event_order_id;
    logic [31:0] amount;
    logic [31:0] taker_filled_now;
    logic        last;
  } result_t;

  typedef struct packed {
    ev_e      ev;
    id_sel_e  id_sel;
    amt_sel_e amt_sel;
    tfn_sel_e tfn_sel;
    logic     last;
  } emit_t;

  typedef struct packed {
    logic    latch;
    logic    clr;
    logic    idx_inc;
    logic    k_inc;
    rd_sel_e rd;
    wr_sel_e wr;
    logic    pop;
    logic    cnt_dec;
    logic    st_rd;
    logic    st_wr;
    logic    tf_set;
    logic    tf_add;
    logic    eval;
    logic    sum_acc;
    logic    out_load;
    emit_t   emit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       is_stop;
    logic       price_ok;
    logic       tf_eq;
    logic       tf_gt;
    logic       idx_eq_cnt;
    logic       next_ge_cnt;
    logic       cnt_zero;
    logic       q_full;
    logic       s_full;
    logic       k_eq_sc;
    logic       key_match;
    logic       rem_gt;
    logic       rem_lt;
    logic       maker_kill;
    logic       taker_aon;
    logic       out_free;
  } sts_t;

endpackage

// File: rtl/plom_order_if.sv
interface plom_order_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] order_id;
  logic [31:0] order_price;
  logic [31:0] order_volume;
  logic [31:0] order_filled;
  logic [1:0]  order_flag;
  logic        is_stop;
  logic [31:0] stop_target_id;

  modport source (output valid, operation, order_id, order_price, order_volume,
                  order_filled, order_flag, is_stop, stop_target_id, input ready);
  modport sink (input valid, operation, order_id, order_price, order_volume,
                order_filled, order_flag, is_stop, stop_target_id, output ready);
endinterface

// File: rtl/plom_event_if.sv
interface plom_event_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [31:0] event_order_id;
  logic [31:0] amount;
  logic [31:0] taker_filled_now;
  logic        last;

  modport source (output valid, event_res, event_order_id, amount, taker_filled_now,
                  last, input ready);
  modport sink (input valid, event_res, event_order_id, amount, taker_filled_now,
                last, output ready);
endinterface

// File: rtl/plom_datapath.sv
module plom_datapath
  import plom_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  item_t       item_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output result_t     res_o,
  output logic        res_valid_o,
  input  logic        res_ready_i
);

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] vol;
    logic [31:0] fil;
    logic [1:0]  flag;
  } entry_t;

  entry_t      q_mem [QUEUE_DEPTH];
  logic [31:0] s_mem [STOP_DEPTH];

  item_t            item_q;
  logic [31:0]      key_q, tf_q, sum_q, rem_q, need_q, lp_q;
  logic [CNT_W-1:0] idx_q, cnt_q;
  logic [PTR_W-1:0] head_q;
  logic [SC_W-1:0]  k_q, sc_q;
  entry_t           q_rd_q;
  logic [31:0]      s_rd_q;
  result_t          out_q;
  logic             ov_q;

  // physical slot of a queue position, counted from the head
  function automatic logic [PTR_W-1:0] phys(logic [PTR_W-1:0] head, logic [CNT_W-1:0] pos);
    logic [PTR_W:0] s;
    s = {1'b0, head} + (PTR_W+1)'(pos);
    if (s >= (PTR_W+1)'(QUEUE_DEPTH)) s = s - (PTR_W+1)'(QUEUE_DEPTH);
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [31:0] remaining(logic [31:0] vol, logic [31:0] fil);
    return (vol > fil) ? vol - fil : 32'd0;
  endfunction

  logic             stop_op;
  logic [PTR_W-1:0] rd_addr, wr_addr, head_inc;
  entry_t           wr_data;
  logic [32:0]      sum_ext;
  logic [31:0]      out_id, out_amt;

  assign stop_op  = item_i.is_stop && (item_i.operation == OP_ADD ||
                                       item_i.operation == OP_CROSS);
  assign head_inc = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign sum_ext  = {1'b0, sum_q} + {1'b0, remaining(q_rd_q.vol, q_rd_q.fil)};

  // queue address and data selection
  always_comb begin
    rd_addr = head_q;
    case (cmd_i.rd)
      RD_IDX:  rd_addr = phys(head_q, idx_q);
      RD_NEXT: rd_addr = phys(head_q, idx_q + 1'b1);
      default: rd_addr = head_q;
    endcase
    wr_addr = phys(head_q, idx_q);
    wr_data = q_rd_q;
    case (cmd_i.wr)
      WR_ITEM: wr_data = '{id: item_q.order_id, vol: item_q.order_volume,
                           fil: item_q.order_filled, flag: item_q.order_flag};
      WR_APPEND: begin
        wr_addr = phys(head_q, cnt_q);
        wr_data = '{id: item_q.order_id, vol: item_q.order_volume,
                    fil: item_q.order_filled, flag: item_q.order_flag};
      end
      WR_PARTIAL: begin
        wr_addr = head_q;
        wr_data = '{id: q_rd_q.id, vol: q_rd_q.vol, fil: q_rd_q.fil + need_q,
                    flag: q_rd_q.flag};
      end
      default: wr_data = q_rd_q;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr != WR_NONE) q_mem[wr_addr] <= wr_data;
    if (cmd_i.rd != RD_NONE) q_rd_q <= q_mem[rd_addr];
    if (cmd_i.st_wr) s_mem[sc_q[SI_W-1:0]] <= item_q.stop_target_id;
    if (cmd_i.st_rd) s_rd_q <= s_mem[k_q[SI_W-1:0]];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= item_i;
      key_q  <= stop_op ? item_i.stop_target_id : item_i.order_id;
    end
    if (cmd_i.eval) begin
      rem_q  <= remaining(q_rd_q.vol, q_rd_q.fil);
      need_q <= item_q.order_volume - tf_q;
    end
  end

  // control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q   <= '0;
      tf_q   <= '0;
      sum_q  <= '0;
      idx_q  <= '0;
      k_q    <= '0;
      cnt_q  <= '0;
      head_q <= '0;
      sc_q   <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (cfg_we_i) lp_q <= cfg_wdata_i;
      if (cmd_i.latch) tf_q <= item_i.order_filled;
      else if (cmd_i.tf_set) tf_q <= item_q.order_volume;
      else if (cmd_i.tf_add) tf_q <= tf_q + rem_q;
      if (cmd_i.clr) begin
        idx_q <= '0;
        k_q   <= '0;
        sum_q <= '0;
      end else begin
        if (cmd_i.idx_inc) idx_q <= idx_q + 1'b1;
        if (cmd_i.k_inc) k_q <= k_q + 1'b1;
        if (cmd_i.sum_acc) sum_q <= sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
      end
      if (cmd_i.wr == WR_APPEND) cnt_q <= cnt_q + 1'b1;
      else if (cmd_i.pop || cmd_i.cnt_dec) cnt_q <= cnt_q - 1'b1;
      if (cmd_i.pop) head_q <= head_inc;
      if (cmd_i.st_wr) sc_q <= sc_q + 1'b1;
      if (cmd_i.out_load) ov_q <= 1'b1;
      else if (res_ready_i) ov_q <= 1'b0;
    end
  end

  // result beat fields
  always_comb begin
    case (cmd_i.emit.id_sel)
      ID_ITEM:  out_id = item_q.order_id;
      ID_MAKER: out_id = q_rd_q.id;
      ID_STOP:  out_id = s_rd_q;
      default:  out_id = '0;
    endcase
    case (cmd_i.emit.amt_sel)
      AMT_NEED: out_amt = need_q;
      AMT_REM:  out_amt = rem_q;
      AMT_TF:   out_amt = tf_q;
      AMT_SUM:  out_amt = sum_q;
      default:  out_amt = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.event_res        <= cmd_i.emit.ev;
      out_q.event_order_id   <= out_id;
      out_q.amount           <= out_amt;
      out_q.taker_filled_now <= (cmd_i.emit.tfn_sel == TFN_TF) ? tf_q : 32'd0;
      out_q.last             <= cmd_i.emit.last;
    end
  end

  assign res_o       = out_q;
  assign res_valid_o = ov_q;

  // status toward the controller
  always_comb begin
    sts_o.op          = item_q.operation;
    sts_o.is_stop     = item_q.is_stop;
    sts_o.price_ok    = (item_q.order_price == lp_q);
    sts_o.tf_eq       = (tf_q == item_q.order_volume);
    sts_o.tf_gt       = (tf_q > item_q.order_volume);
    sts_o.idx_eq_cnt  = (idx_q == cnt_q);
    sts_o.next_ge_cnt = ({1'b0, idx_q} + 1'b1 >= {1'b0, cnt_q});
    sts_o.cnt_zero    = (cnt_q == '0);
    sts_o.q_full      = (cnt_q == CNT_W'(QUEUE_DEPTH));
    sts_o.s_full      = (sc_q == SC_W'(STOP_DEPTH));
    sts_o.k_eq_sc     = (k_q == sc_q);
    sts_o.key_match   = (q_rd_q.id == key_q);
    sts_o.rem_gt      = (rem_q > need_q);
    sts_o.rem_lt      = (rem_q < need_q);
    sts_o.maker_kill  = (q_rd_q.flag == FLAG_FOK) || (q_rd_q.flag == FLAG_AON);
    sts_o.taker_aon   = (item_q.order_flag == FLAG_AON);
    sts_o.out_free    = !ov_q || res_ready_i;
  end

endmodule

// File: rtl/plom_controller.sv
module plom_controller
  import plom_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_LOC_RD, S_LOC_CMP, S_AFTER_LOC, S_ER_RD, S_ER_WR, S_ER_FIN,
    S_CR_RD, S_CR_EVAL, S_CR_DEC, S_CR_SECOND, S_CR_END, S_ST_RD, S_ST_EM,
    S_VOL_RD, S_VOL_ACC, S_EMIT
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;
  emit_t  emit_q, emit_d, emit2_q, emit2_d;
  ev_e    fin_q, fin_d;
  logic   found_q, found_d;

  function automatic emit_t mk(ev_e ev, id_sel_e ids, amt_sel_e amt, tfn_sel_e tfn,
                               logic last);
    emit_t e;
    e.ev = ev;
    e.id_sel = ids;
    e.amt_sel = amt;
    e.tfn_sel = tfn;
    e.last = last;
    return e;
  endfunction

  logic stop_op;
  assign stop_op = sts_i.is_stop && (sts_i.op == OP_ADD || sts_i.op == OP_CROSS);

  // next state and commands
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    emit_d  = emit_q;
    emit2_d = emit2_q;
    fin_d   = fin_q;
    found_d = found_q;
    cmd_o   = '0;
    cmd_o.rd = RD_NONE;
    cmd_o.wr = WR_NONE;
    cmd_o.emit = emit_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd_o.clr = 1'b1;
        ret_d = S_IDLE;
        state_d = S_EMIT;
        if (stop_op || sts_i.op == OP_ADD) begin
          state_d = S_LOC_RD;
        end else begin
          case (sts_i.op)
            OP_FIND:
              if (sts_i.price_ok) state_d = S_LOC_RD;
              else emit_d = mk(EV_NOTFOUND, ID_ITEM, AMT_ZERO, TFN_ZERO, 1'b1);
            OP_MODIFY, OP_REMOVE:
              if (sts_i.price_ok) state_d = S_LOC_RD;
              else emit_d = mk(EV_MISSING, ID_ITEM, AMT_ZERO, TFN_ZERO, 1'b1);
            OP_CROSS:
              if (sts_i.tf_eq) begin
                fin_d = EV_DONE;
                state_d = S_ST_RD;
              end else if (sts_i.tf_gt) begin
                emit_d = mk(EV_CORRUPT, ID_ITEM, AMT_ZERO, TFN_TF, 1'b1);
              end else begin
                state_d = S_CR_RD;
              end
            OP_VOLUME: state_d = S_VOL_RD;
            default: emit_d = mk(EV_IGNORED, ID_ITEM, AMT_ZERO, TFN_ZERO, 1'b1);
          endcase
        end
      end
      // linear search for the key
      S_LOC_RD: begin
        if (sts_i.idx_eq_cnt) begin
          found_d = 1'b0;
          state_d = S_AFTER_LOC;
        end else begin
          cmd_o.rd = RD_IDX;
          state_d = S_LOC_CMP;
        end
      end
      S_LOC_CMP: begin
        if (sts_i.key_match) begin
          found_d = 1'b1;
          state_d = S_AFTER_LOC;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = S_LOC_RD;
        end
      end
      S_AFTER_LOC: begin
        ret_d = S_IDLE;
        state_d = S_EMIT;
        if (stop_op) begin
          if (found_q) emit_d = mk(EV_IGNORED, ID_ITEM, AMT_ZERO, TFN_ZERO, 1'b1);
          else if (sts_i.s_full) emit_d = mk(EV_CORRUPT, ID_ITEM, AMT_ZERO, TFN_ZERO, 1'b1);
          else begin
            cmd_o.st_wr = 1'b1;
            emit_d = mk(EV_DONE, ID_ITEM, AMT_ZERO, TFN_ZERO, 1'b1);
          end
        end else begin
          case (sts_i.op)
            OP_ADD:
              if (found_q) begin
                cmd_o.wr = WR_ITEM;
                emit_d = mk(EV_CHANGE, ID_ITEM, AMT_ZERO, TFN_ZERO, 1'b1);
              end else if (sts_i.q_full) begin
                emit_d = mk(EV_CORRUPT, ID_ITEM, AMT_ZERO, TFN_ZERO, 1'b1);
              end else begin
                cmd_o.wr = WR_APPEND;
                emit_d = mk(EV_OPEN, ID_ITEM, AMT_ZERO, TFN_ZERO, 1'b1);
              end
            OP_FIND:
              emit_d = mk(found_q ? EV_FOUND : EV_NOTFOUND, ID_ITEM, AMT_ZERO,
                          TFN_ZERO, 1'b1);
            default:
              if (!found_q) begin
                emit_d = mk(EV_MISSING, ID_ITEM, AMT_ZERO, TFN_ZERO, 1'b1);
              end else begin
                emit_d = mk((sts_i.op == OP_MODIFY) ? EV_CHANGE : EV_CANCEL, ID_ITEM,
                            AMT_ZERO, TFN_ZERO, 1'b1);
                state_d = S_ER_RD;
              end
          endcase
        end
      end
      // close the gap left by an erased entry
      S_ER_RD: begin
        if (sts_i.next_ge_cnt) state_d = S_ER_FIN;
        else begin
          cmd_o.rd = RD_NEXT;
          state_d = S_ER_WR;
        end
      end
      S_ER_WR: begin
        cmd_o.wr = WR_SHIFT;
        cmd_o.idx_inc = 1'b1;
        state_d = S_ER_RD;
      end
      S_ER_FIN: begin
        cmd_o.cnt_dec = 1'b1;
        state_d = S_EMIT;
      end
      // matching loop against the front maker
      S_CR_RD: begin
        if (sts_i.tf_eq || sts_i.cnt_zero) state_d = S_CR_END;
        else begin
          cmd_o.rd = RD_FRONT;
          state_d = S_CR_EVAL;
        end
      end
      S_CR_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = S_CR_DEC;
      end
      S_CR_DEC: begin
        state_d = S_EMIT;
        ret_d = S_CR_SECOND;
        if (sts_i.rem_gt) begin
          if (sts_i.maker_kill) begin
            cmd_o.pop = 1'b1;
            emit_d = mk(EV_CANCEL, ID_MAKER, AMT_ZERO, TFN_TF, 1'b0);
            ret_d = S_CR_RD;
          end else begin
            cmd_o.wr = WR_PARTIAL;
            cmd_o.tf_set = 1'b1;
            emit_d  = mk(EV_FILL, ID_ITEM, AMT_NEED, TFN_TF, 1'b0);
            emit2_d = mk(EV_CHANGE, ID_MAKER, AMT_NEED, TFN_TF, 1'b0);
          end
        end else if (sts_i.rem_lt) begin
          cmd_o.tf_add = 1'b1;
          if (sts_i.taker_aon) begin
            fin_d = EV_DONE;
            state_d = S_ST_RD;
          end else begin
            cmd_o.pop = 1'b1;
            emit_d  = mk(EV_CHANGE, ID_ITEM, AMT_REM, TFN_TF, 1'b0);
            emit2_d = mk(EV_FILL, ID_MAKER, AMT_REM, TFN_TF, 1'b0);
          end
        end else begin
          cmd_o.tf_add = 1'b1;
          cmd_o.pop = 1'b1;
          emit_d  = mk(EV_FILL, ID_ITEM, AMT_NEED, TFN_TF, 1'b0);
          emit2_d = mk(EV_FILL, ID_MAKER, AMT_NEED, TFN_TF, 1'b0);
        end
      end
      S_CR_SECOND: begin
        emit_d = emit2_q;
        ret_d = S_CR_RD;
        state_d = S_EMIT;
      end
      S_CR_END: begin
        if (sts_i.tf_eq) begin
          fin_d = EV_DONE;
          emit_d = mk(EV_TRADE, ID_ITEM, AMT_TF, TFN_TF, 1'b0);
          ret_d = S_ST_RD;
          state_d = S_EMIT;
        end else begin
          fin_d = EV_REMAIN;
          state_d = S_ST_RD;
        end
      end
      // stop releases, then the closing beat
      S_ST_RD: begin
        state_d = S_EMIT;
        if (sts_i.k_eq_sc) begin
          emit_d = mk(fin_q, ID_ITEM, AMT_ZERO, TFN_TF, 1'b1);
          ret_d = S_IDLE;
        end else begin
          cmd_o.st_rd = 1'b1;
          state_d = S_ST_EM;
        end
      end
      S_ST_EM: begin
        cmd_o.k_inc = 1'b1;
        emit_d = mk(EV_STOP, ID_STOP, AMT_ZERO, TFN_TF, 1'b0);
        ret_d = S_ST_RD;
        state_d = S_EMIT;
      end
      // level volume
      S_VOL_RD: begin
        if (sts_i.idx_eq_cnt) begin
          emit_d = mk(EV_VOLUME, ID_ZERO, AMT_SUM, TFN_ZERO, 1'b1);
          ret_d = S_IDLE;
          state_d = S_EMIT;
        end else begin
          cmd_o.rd = RD_IDX;
          state_d = S_VOL_ACC;
        end
      end
      S_VOL_ACC: begin
        cmd_o.sum_acc = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d = S_VOL_RD;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ret_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      emit_q  <= '0;
      emit2_q <= '0;
      fin_q   <= EV_DONE;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      emit_q  <= emit_d;
      emit2_q <= emit2_d;
      fin_q   <= fin_d;
      found_q <= found_d;
    end
  end

endmodule

// File: rtl/price_level_order_matcher.sv
// One price level with a time-ordered queue of resting orders and a list of
// stop targets. One order beat is taken at a time; it answers with one or more
// event beats, the final one marked last. Add, find, modify, remove and volume
// query walk the queue entries in turn (a linear search over the queue memory),
// modify/remove then shift the later entries forward over the erased one, a
// cross takes makers from the front, stops are released one by one, and each
// event beat waits while the output is stalled.
// level_price may be written only while no order beat is in progress.
module price_level_order_matcher
  import plom_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  plom_order_if.sink  order_i,
  plom_event_if.source event_o
);

  item_t   item;
  result_t res;
  cmd_t    cmd;
  sts_t    sts;
  logic    res_valid;
  logic    in_ready;

  assign item.operation      = order_i.operation;
  assign item.order_id       = order_i.order_id;
  assign item.order_price    = order_i.order_price;
  assign item.order_volume   = order_i.order_volume;
  assign item.order_filled   = order_i.order_filled;
  assign item.order_flag     = order_i.order_flag;
  assign item.is_stop        = order_i.is_stop;
  assign item.stop_target_id = order_i.stop_target_id;
  assign order_i.ready       = in_ready;

  assign event_o.valid            = res_valid;
  assign event_o.event_res        = res.event_res;
  assign event_o.event_order_id   = res.event_order_id;
  assign event_o.amount           = res.amount;
  assign event_o.taker_filled_now = res.taker_filled_now;
  assign event_o.last             = res.last;

  plom_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (order_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  plom_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (event_o.ready)
  );

endmodule

// File: tb/plom_checker.sv
module plom_checker
  import plom_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  plom_order_if       ord,
  plom_event_if       evt,
  output int          fail_cnt_o,
  output int          pending_o
);

  // mirrored level state
  logic [31:0] price_q;
  logic [31:0] rest_id  [QUEUE_DEPTH];
  logic [31:0] rest_vol [QUEUE_DEPTH];
  logic [31:0] rest_fil [QUEUE_DEPTH];
  logic [1:0]  rest_flag[QUEUE_DEPTH];
  int          rest_cnt;
  logic [31:0] stop_tgt [STOP_DEPTH];
  int          stop_cnt;

  result_t     event_q[$];
  int          fails;

  function automatic void push_event(ev_e e, logic [31:0] id, logic [31:0] amt,
                                     logic [31:0] tfn);
    result_t r;
    r.event_res        = e;
    r.event_order_id   = id;
    r.amount           = amt;
    r.taker_filled_now = tfn;
    r.last             = 1'b0;
    event_q.insert(event_q.size(), r);
  endfunction

  function automatic int find_rest(logic [31:0] id);
    for (int i = 0; i < rest_cnt; i++) if (rest_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_rest(int at);
    for (int i = at; i + 1 < rest_cnt; i++) begin
      rest_id[i]   = rest_id[i+1];
      rest_vol[i]  = rest_vol[i+1];
      rest_fil[i]  = rest_fil[i+1];
      rest_flag[i] = rest_flag[i+1];
    end
    if (rest_cnt > 0) rest_cnt--;
  endfunction

  function automatic void requeue_front(logic [31:0] id, logic [31:0] v, logic [31:0] f,
                                        logic [1:0] fl);
    for (int i = rest_cnt; i > 0; i--) begin
      if (i < QUEUE_DEPTH) begin
        rest_id[i]   = rest_id[i-1];
        rest_vol[i]  = rest_vol[i-1];
        rest_fil[i]  = rest_fil[i-1];
        rest_flag[i] = rest_flag[i-1];
      end
    end
    rest_id[0] = id; rest_vol[0] = v; rest_fil[0] = f; rest_flag[0] = fl;
    if (rest_cnt < QUEUE_DEPTH) rest_cnt++;
  endfunction

  function automatic logic [31:0] open_lots(logic [31:0] v, logic [31:0] f);
    return (v > f) ? v - f : 32'd0;
  endfunction

  function automatic void arm_stop(logic [31:0] id, logic [31:0] tgt);
    if (find_rest(tgt) >= 0) push_event(EV_IGNORED, id, 0, 0);
    else if (stop_cnt >= STOP_DEPTH) push_event(EV_CORRUPT, id, 0, 0);
    else begin
      stop_tgt[stop_cnt++] = tgt;
      push_event(EV_DONE, id, 0, 0);
    end
  endfunction

  function automatic void fire_stops(logic [31:0] tf);
    for (int i = 0; i < stop_cnt; i++) push_event(EV_STOP, stop_tgt[i], 0, tf);
  endfunction

  // taker walks the queue from the front
  function automatic void match_taker(logic [31:0] id, logic [31:0] tv, logic [31:0] tf_in,
                                      logic [1:0] tflag);
    logic [31:0] tf, need, mid, mv, mf, r;
    logic [1:0]  mfl;
    tf = tf_in;
    if (tf == tv) begin
      fire_stops(tf);
      push_event(EV_DONE, id, 0, tf);
      return;
    end
    if (tf > tv) begin
      push_event(EV_CORRUPT, id, 0, tf);
      return;
    end
    while (tf < tv && rest_cnt > 0) begin
      need = tv - tf;
      mid = rest_id[0]; mv = rest_vol[0]; mf = rest_fil[0]; mfl = rest_flag[0];
      r = open_lots(mv, mf);
      drop_rest(0);
      if (r > need) begin
        if (mfl == FLAG_FOK || mfl == FLAG_AON) begin
          push_event(EV_CANCEL, mid, 0, tf);
          continue;
        end
        tf = tv;
        requeue_front(mid, mv, mf + need, mfl);
        push_event(EV_FILL, id, need, tf);
        push_event(EV_CHANGE, mid, need, tf);
      end else if (r < need) begin
        tf += r;
        if (tflag == FLAG_AON) begin
          requeue_front(mid, mv, mf, mfl);
          fire_stops(tf);
          push_event(EV_DONE, id, 0, tf);
          return;
        end
        push_event(EV_CHANGE, id, r, tf);
        push_event(EV_FILL, mid, r, tf);
      end else begin
        tf += r;
        push_event(EV_FILL, id, need, tf);
        push_event(EV_FILL, mid, need, tf);
      end
    end
    if (tf == tv) begin
      push_event(EV_TRADE, id, tf, tf);
      fire_stops(tf);
      push_event(EV_DONE, id, 0, tf);
    end else begin
      fire_stops(tf);
      push_event(EV_REMAIN, id, 0, tf);
    end
  endfunction

  function automatic void predict_beat();
    int          at;
    logic [63:0] sum;
    logic [31:0] id;
    id = ord.order_id;
    case (ord.operation)
      OP_ADD: begin
        if (ord.is_stop) arm_stop(id, ord.stop_target_id);
        else begin
          at = find_rest(id);
          if (at >= 0) begin
            rest_vol[at] = ord.order_volume;
            rest_fil[at] = ord.order_filled;
            rest_flag[at] = ord.order_flag;
            push_event(EV_CHANGE, id, 0, 0);
          end else if (rest_cnt >= QUEUE_DEPTH) begin
            push_event(EV_CORRUPT, id, 0, 0);
          end else begin
            rest_id[rest_cnt]   = id;
            rest_vol[rest_cnt]  = ord.order_volume;
            rest_fil[rest_cnt]  = ord.order_filled;
            rest_flag[rest_cnt] = ord.order_flag;
            rest_cnt++;
            push_event(EV_OPEN, id, 0, 0);
          end
        end
      end
      OP_FIND: begin
        at = (ord.order_price == price_q) ? find_rest(id) : -1;
        push_event(at >= 0 ? EV_FOUND : EV_NOTFOUND, id, 0, 0);
      end
      OP_MODIFY, OP_REMOVE: begin
        at = (ord.order_price == price_q) ? find_rest(id) : -1;
        if (at < 0) push_event(EV_MISSING, id, 0, 0);
        else begin
          drop_rest(at);
          push_event(ord.operation == OP_MODIFY ? EV_CHANGE : EV_CANCEL, id, 0, 0);
        end
      end
      OP_CROSS: begin
        if (ord.is_stop) arm_stop(id, ord.stop_target_id);
        else match_taker(id, ord.order_volume, ord.order_filled, ord.order_flag);
      end
      OP_VOLUME: begin
        sum = '0;
        for (int i = 0; i < rest_cnt; i++) sum += open_lots(rest_vol[i], rest_fil[i]);
        if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
        push_event(EV_VOLUME, 0, sum[31:0], 0);
      end
      default: push_event(EV_IGNORED, id, 0, 0);
    endcase
    event_q[event_q.size()-1].last = 1'b1;
  endfunction

  // predict on order beats, compare on event beats
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      price_q  <= '0;
      rest_cnt = 0;
      stop_cnt = 0;
      fails    = 0;
      event_q.delete();
    end else begin
      if (cfg_we_i) price_q <= cfg_wdata_i;
      if (ord.valid && ord.ready) predict_beat();
      if (evt.valid && evt.ready) begin
        if (event_q.size() == 0) begin
          $error("unexpected event beat: event_res %0d id %0d", evt.event_res,
                 evt.event_order_id);
          fails++;
        end else begin
          want = event_q[0];
          event_q.delete(0);
          if (evt.event_res !== want.event_res) begin
            $error("event_res: expected %0d, got %0d", want.event_res, evt.event_res);
            fails++;
          end
          if (evt.event_order_id !== want.event_order_id) begin
            $error("event_order_id: expected %0d, got %0d", want.event_order_id,
                   evt.event_order_id);
            fails++;
          end
          if (evt.amount !== want.amount) begin
            $error("amount: expected %0d, got %0d", want.amount, evt.amount);
            fails++;
          end
          if (evt.taker_filled_now !== want.taker_filled_now) begin
            $error("taker_filled_now: expected %0d, got %0d", want.taker_filled_now,
                   evt.taker_filled_now);
            fails++;
          end
          if (evt.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, evt.last);
            fails++;
          end
        end
      end
    end
    fail_cnt_o = fails;
    pending_o  = event_q.size();
  end

endmodule

// File: tb/testbench.sv
module testbench;
  import plom_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic [31:0] lvl;
  logic        burst_mode;
  logic        hold_req;
  int          fail_cnt;
  int          pending;
  int          quiet_cycles;

  plom_order_if ord();
  plom_event_if evt();

  always #5 clk_i = ~clk_i;

  price_level_order_matcher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .order_i    (ord),
    .event_o    (evt)
  );

  plom_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .ord        (ord),
    .evt        (evt),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  function automatic int draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 17);
  endfunction

  // one order beat; valid stays high across back-to-back beats
  task automatic send_order(logic [2:0] op, logic [31:0] id, logic [31:0] price,
                            logic [31:0] vol, logic [31:0] fil, logic [1:0] flag,
                            logic stop, logic [31:0] tgt);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      ord.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    ord.valid          <= 1'b1;
    ord.operation      <= op;
    ord.order_id       <= id;
    ord.order_price    <= price;
    ord.order_volume   <= vol;
    ord.order_filled   <= fil;
    ord.order_flag     <= flag;
    ord.is_stop        <= stop;
    ord.stop_target_id <= tgt;
    do @(posedge clk_i); while (!ord.ready);
  endtask

  // drain in-flight events, then write the level price
  task automatic set_level(logic [31:0] p);
    ord.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    lvl       = p;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_order();
    logic [2:0]  op;
    logic [31:0] id, price, vol, fil, tgt;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      op = OP_ADD;
    else if (pick < 60) op = OP_CROSS;
    else if (pick < 68) op = OP_FIND;
    else if (pick < 76) op = OP_MODIFY;
    else if (pick < 85) op = OP_REMOVE;
    else if (pick < 93) op = OP_VOLUME;
    else if (pick < 97) op = OP_ADD;
    else                op = 3'($urandom_range(6, 7));
    id    = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 12);
    price = ($urandom_range(0, 6) == 0) ? $urandom() : lvl;
    if ($urandom_range(0, 7) == 0) begin
      vol = $urandom();
      fil = $urandom();
    end else begin
      vol = $urandom_range(1, 20);
      fil = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 25) : $urandom_range(0, vol);
    end
    tgt = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 14);
    send_order(op, id, price, vol, fil, 2'($urandom_range(0, 3)),
               (pick >= 93 && pick < 97) || $urandom_range(0, 29) == 0, tgt);
  endtask

  // event side: random stalls, plus one long hold on request
  initial begin
    int gap;
    evt.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        evt.ready <= 1'b0;
        repeat (600) @(posedge clk_i);
        hold_req = 1'b0;
      end
      gap = draw_gap();
      if (gap > 0) begin
        evt.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      evt.ready <= 1'b1;
      do @(posedge clk_i); while (!evt.valid);
    end
  end

  // stall watchdog
  always @(posedge clk_i) begin
    if ((ord.valid && ord.ready) || (evt.valid && evt.ready) ||
        (pending == 0 && !ord.valid))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[price_level_order_matcher] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni     <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    burst_mode = 1'b0;
    hold_req   = 1'b0;
    lvl        = '0;
    quiet_cycles <= 0;
    ord.valid <= 1'b0;
    ord.operation <= OP_ADD;
    ord.order_id <= '0;
    ord.order_price <= '0;
    ord.order_volume <= '0;
    ord.order_filled <= '0;
    ord.order_flag <= '0;
    ord.is_stop <= 1'b0;
    ord.stop_target_id <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty level, corner crosses, flags, stops, lookups
    set_level(32'd100);
    send_order(OP_VOLUME, 0, 0, 0, 0, 0, 0, 0);
    send_order(OP_CROSS, 50, 100, 10, 0, 0, 0, 0);
    send_order(OP_CROSS, 51, 100, 7, 7, 0, 0, 0);
    send_order(OP_CROSS, 52, 100, 3, 9, 0, 0, 0);
    send_order(OP_ADD, 1, 100, 10, 0, 0, 0, 0);
    send_order(OP_ADD, 2, 100, 50, 0, FLAG_FOK, 0, 0);
    send_order(OP_ADD, 3, 100, 5, 0, FLAG_AON, 0, 0);
    send_order(OP_ADD, 4, 100, 4, 9, 2'd3, 0, 0);
    send_order(OP_ADD, 1, 100, 12, 2, 0, 0, 0);
    send_order(OP_ADD, 60, 100, 0, 0, 0, 1, 99);
    send_order(OP_ADD, 61, 100, 0, 0, 0, 1, 1);
    send_order(OP_CROSS, 62, 100, 0, 0, 0, 1, 98);
    send_order(OP_FIND, 1, 100, 0, 0, 0, 0, 0);
    send_order(OP_FIND, 1, 101, 0, 0, 0, 0, 0);
    send_order(OP_FIND, 77, 100, 0, 0, 0, 0, 0);
    send_order(OP_VOLUME, 0, 0, 0, 0, 0, 0, 0);
    send_order(OP_REMOVE, 77, 100, 0, 0, 0, 0, 0);
    send_order(OP_MODIFY, 3, 99, 0, 0, 0, 0, 0);
    send_order(OP_CROSS, 70, 100, 8, 0, 0, 0, 0);
    send_order(OP_CROSS, 71, 100, 100, 0, FLAG_AON, 0, 0);
    send_order(OP_CROSS, 72, 100, 30, 0, 0, 0, 0);
    send_order(OP_ADD, 5, 100, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_order(OP_ADD, 6, 100, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_order(OP_VOLUME, 0, 0, 0, 0, 0, 0, 0);
    send_order(3'd6, 80, 0, 0, 0, 0, 0, 0);
    send_order(3'd7, 81, 0, 0, 0, 0, 0, 0);

    // fill both the queue and the stop list past capacity
    for (int i = 0; i < QUEUE_DEPTH + 1; i++)
      send_order(OP_ADD, 200 + i, 100, 2, 0, 0, 0, 0);
    for (int i = 0; i < STOP_DEPTH + 1; i++)
      send_order(OP_ADD, 300, 100, 0, 0, 0, 1, 400 + i);
    send_order(OP_CROSS, 90, 100, 32'hFFFF_FFFF, 0, 0, 0, 0);

    // random phases over several level prices, the extremes among them
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_level(32'd0);
        1: set_level(32'hFFFF_FFFF);
        default: set_level($urandom());
      endcase
      burst_mode = (ph == 3);
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < 12; n++) random_order();
    end
    ord.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("[price_level_order_matcher] OK");
    else
      $display("[price_level_order_matcher] ERROR");
    $finish;
  end

endmodule
